[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL modules of the bipartization search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/gr6_pkg.sv]
// Package with the item types and fixed constants of the bipartization search block.
package gr6_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } byte_item_t;

    typedef struct packed {
        logic [6:0]  edge_count;
        logic [6:0]  min_mono_edges;
        logic        lp_gap;
        logic        tight;
        logic [31:0] graphs_seen;
        logic [6:0]  max_min_mono;
        logic [31:0] gap_total;
        logic [31:0] tight_total;
    } res_item_t;

    localparam int          ADDR_W             = 3;
    localparam logic        REG_VERTEX_COUNT   = 1'b0;
    localparam logic [4:0]  VERTEX_COUNT_RESET = 5'd12;
    localparam int          MIN_VERTICES       = 2;
    localparam logic [7:0]  SIZE_OFFSET        = 8'd63;
    localparam logic [7:0]  HEADER_SKIP_CHAR   = 8'h3e;
    localparam int          GAP_FACTOR         = 5;
    localparam int          TIGHT_FACTOR       = 25;
    localparam logic [31:0] TALLY_MAX          = 32'hffff_ffff;
    localparam logic [2:0]  LAST_BIT_SLOT      = 3'd5;

endpackage

[rtl/core/gr6_cfg.sv]
// APB register file holding the vertex count.
module gr6_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [gr6_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [4:0]                vertex_count
);
    import gr6_pkg::*;

    logic [4:0] vertex_count_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end
        else if (wr_en)
        begin
            vertex_count_reg <= pwdata[4:0];
        end
    end

    assign prdata       = (paddr[2] == REG_VERTEX_COUNT) ? {27'd0, vertex_count_reg} : 32'd0;
    assign vertex_count = vertex_count_reg;

endmodule

[rtl/core/gr6_flip_unit.sv]
// Shared flip unit: updates the monochromatic edge count when one vertex changes side.
module gr6_flip_unit #(
    parameter int MAX_VERTICES = 16,
    parameter int EW           = 7
) (
    input  logic [MAX_VERTICES-1:0]         row,
    input  logic [MAX_VERTICES-1:0]         side,
    input  logic [$clog2(MAX_VERTICES)-1:0] flip,
    input  logic [EW-1:0]                   mono,
    output logic [EW-1:0]                   mono_new
);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [MAX_VERTICES-1:0] same_mask;
    logic [MAX_VERTICES-1:0] same_bits;
    logic [MAX_VERTICES-1:0] other_bits;
    logic [CW-1:0]           same_cnt;
    logic [CW-1:0]           other_cnt;

    assign same_mask  = side[flip] ? side : ~side;
    assign same_bits  = row & same_mask;
    assign other_bits = row & ~same_mask;

    always_comb
    begin
        same_cnt  = '0;
        other_cnt = '0;
        for (int b = 0; b < MAX_VERTICES; b++)
        begin
            same_cnt  = same_cnt + CW'(same_bits[b]);
            other_cnt = other_cnt + CW'(other_bits[b]);
        end
    end

    assign mono_new = mono + EW'(other_cnt) - EW'(same_cnt);

endmodule

[rtl/core/gr6_stats.sv]
// Result flags, running tallies and the result output register.
`include "assert_macros.svh"

module gr6_stats #(
    parameter int MAX_VERTICES = 16,
    parameter int EW           = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fin_valid,
    output logic                 fin_ready,
    input  logic [EW-1:0]        fin_edge,
    input  logic [EW-1:0]        fin_best,
    input  logic [4:0]           fin_n,
    output logic                 res_valid,
    input  logic                 res_ready,
    output gr6_pkg::res_item_t   res_item
);
    import gr6_pkg::*;

    localparam int GW = EW + 3;
    localparam int TW = (EW + 5 > 10) ? EW + 5 : 10;

    logic              res_valid_reg;
    logic              res_valid_next;
    res_item_t         res_item_reg;
    logic [31:0]       graph_tally_reg;
    logic [31:0]       graph_tally_next;
    logic [31:0]       gap_tally_reg;
    logic [31:0]       gap_tally_next;
    logic [31:0]       tight_tally_reg;
    logic [31:0]       tight_tally_next;
    logic [EW-1:0]     best_seen_reg;
    logic [EW-1:0]     best_seen_next;
    logic              fire;
    logic [GW-1:0]     best_x5;
    logic [TW-1:0]     best_x25;
    logic [TW-1:0]     n_sq;
    logic              gap;
    logic              tight;
    logic [EW+6:0]     edge_ext;
    logic [EW+6:0]     best_ext;
    logic [EW+6:0]     seen_ext;

    assign fin_ready = !res_valid_reg || res_ready;
    assign fire      = fin_valid && fin_ready;

    assign best_x5  = GW'(fin_best) * GW'(GAP_FACTOR);
    assign best_x25 = TW'(fin_best) * TW'(TIGHT_FACTOR);
    assign n_sq     = TW'(fin_n) * TW'(fin_n);
    assign gap      = best_x5 > GW'(fin_edge);
    assign tight    = best_x25 >= n_sq;

    always_comb
    begin
        graph_tally_next = graph_tally_reg;
        gap_tally_next   = gap_tally_reg;
        tight_tally_next = tight_tally_reg;
        best_seen_next   = best_seen_reg;
        res_valid_next   = res_valid_reg;
        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (fire)
        begin
            res_valid_next = 1'b1;
            if (graph_tally_reg != TALLY_MAX)
            begin
                graph_tally_next = graph_tally_reg + 32'd1;
            end
            if (gap && (gap_tally_reg != TALLY_MAX))
            begin
                gap_tally_next = gap_tally_reg + 32'd1;
            end
            if (tight && (tight_tally_reg != TALLY_MAX))
            begin
                tight_tally_next = tight_tally_reg + 32'd1;
            end
            if (fin_best > best_seen_reg)
            begin
                best_seen_next = fin_best;
            end
        end
    end

    assign edge_ext = (EW + 7)'(fin_edge);
    assign best_ext = (EW + 7)'(fin_best);
    assign seen_ext = (EW + 7)'(best_seen_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg   <= 1'b0;
            graph_tally_reg <= '0;
            gap_tally_reg   <= '0;
            tight_tally_reg <= '0;
            best_seen_reg   <= '0;
        end
        else
        begin
            res_valid_reg   <= res_valid_next;
            graph_tally_reg <= graph_tally_next;
            gap_tally_reg   <= gap_tally_next;
            tight_tally_reg <= tight_tally_next;
            best_seen_reg   <= best_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_item_reg.edge_count     <= edge_ext[6:0];
            res_item_reg.min_mono_edges <= best_ext[6:0];
            res_item_reg.lp_gap         <= gap;
            res_item_reg.tight          <= tight;
            res_item_reg.graphs_seen    <= graph_tally_next;
            res_item_reg.max_min_mono   <= seen_ext[6:0];
            res_item_reg.gap_total      <= gap_tally_next;
            res_item_reg.tight_total    <= tight_tally_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `ASSERT_ALWAYS(a_gap_within_graphs, gap_tally_reg <= graph_tally_reg, "gap tally passed graph tally")
    `ASSERT_ALWAYS(a_tight_within_graphs, tight_tally_reg <= graph_tally_reg, "tight tally passed graph tally")

endmodule

[rtl/core/graph6_min_bipartization_search_top.sv]
// Top level: graph6 byte decoder, bipartition search sequencer and adjacency rows.
//
// Usage:
//   byte channel (byte_valid/byte_ready/byte_item) carries one graph6 byte per request,
//   with line_end set on the last byte of a line. The first byte is the size byte.
//   res channel (res_valid/res_ready/res_item) returns one result per evaluated line.
//   APB register 0 holds vertex_count; write it only while the block is idle.
// Timing:
//   A size byte is checked in the idle state. For a data byte, six triangle bits go into
//   the adjacency rows one per cycle. At line end the search runs through the shared
//   flip unit, one Gray-code step per cycle, and stops early when a zero-cost split
//   turns up. The result register loads from the finish state once the stats unit
//   can take the result. No new byte is taken while a line is decoded or searched.
// Reset:
//   Clears line state, the adjacency rows and all tallies; vertex_count returns to 12.
// Stall:
//   A waiting result does not block the next line; a second finished result holds
//   in the search unit until the first is taken.
`include "assert_macros.svh"

module graph6_min_bipartization_search_top #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gr6_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       byte_valid,
    output logic                       byte_ready,
    input  gr6_pkg::byte_item_t        byte_item,
    output logic                       res_valid,
    input  logic                       res_ready,
    output gr6_pkg::res_item_t         res_item
);
    import gr6_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int JW = $clog2(MAX_VERTICES + 1);
    localparam int EW = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
    localparam int KW = MAX_VERTICES - 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [5:0]              val_reg;
    logic [5:0]              val_next;
    logic                    last_reg;
    logic                    last_next;
    logic [2:0]              bit_cnt_reg;
    logic [2:0]              bit_cnt_next;
    logic [4:0]              byte_index_reg;
    logic [4:0]              byte_index_next;
    logic                    skip_reg;
    logic                    skip_next;
    logic [VW-1:0]           pos_i_reg;
    logic [VW-1:0]           pos_i_next;
    logic [JW-1:0]           pos_j_reg;
    logic [JW-1:0]           pos_j_next;
    logic [EW-1:0]           edge_reg;
    logic [EW-1:0]           edge_next;
    logic [MAX_VERTICES-1:0] side_reg;
    logic [MAX_VERTICES-1:0] side_next;
    logic [EW-1:0]           mono_reg;
    logic [EW-1:0]           mono_next;
    logic [EW-1:0]           best_reg;
    logic [EW-1:0]           best_next;
    logic [KW-1:0]           step_reg;
    logic [KW-1:0]           step_next;
    logic [VW-1:0]           flip_reg;
    logic [VW-1:0]           flip_next;
    logic [MAX_VERTICES-1:0] rows_reg [MAX_VERTICES];

    logic [4:0]              vertex_count;
    logic                    n_ok;
    logic                    byte_fire;
    logic [7:0]              size_val;
    logic                    skip_new;
    logic                    decode_go;
    logic                    cur_bit;
    logic                    place_en;
    logic                    line_clear;
    logic [EW-1:0]           mono_new;
    logic [KW-1:0]           step_inc;
    logic [KW-1:0]           step_last;
    logic [VW-1:0]           tz;
    logic                    tz_found;
    logic [VW-1:0]           flip_after;
    logic                    fin_valid;
    logic                    fin_ready;

    gr6_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .vertex_count (vertex_count)
    );

    assign byte_ready = (state_reg == ST_IDLE);
    assign byte_fire  = byte_valid && byte_ready;
    assign n_ok       = (32'(vertex_count) >= MIN_VERTICES)
                        && (32'(vertex_count) <= MAX_VERTICES);
    assign size_val   = byte_item.char_byte - SIZE_OFFSET;
    assign skip_new   = skip_reg || !n_ok
                        || ((byte_index_reg == 5'd0)
                            && ((byte_item.char_byte == HEADER_SKIP_CHAR)
                                || (size_val != {3'd0, vertex_count})));
    assign decode_go  = (byte_index_reg != 5'd0) && !skip_new;
    assign cur_bit    = val_reg[LAST_BIT_SLOT - bit_cnt_reg];

    gr6_flip_unit #(
        .MAX_VERTICES (MAX_VERTICES),
        .EW           (EW)
    ) u_flip (
        .row      (rows_reg[flip_reg]),
        .side     (side_reg),
        .flip     (flip_reg),
        .mono     (mono_reg),
        .mono_new (mono_new)
    );

    assign step_inc = step_reg + 1'b1;

    always_comb
    begin
        tz       = '0;
        tz_found = 1'b0;
        for (int b = 0; b < KW; b++)
        begin
            step_last[b] = (b < 32'(vertex_count) - 1);
            if (!tz_found && step_inc[b])
            begin
                tz       = VW'(b);
                tz_found = 1'b1;
            end
        end
    end

    assign flip_after = tz + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        val_next        = val_reg;
        last_next       = last_reg;
        bit_cnt_next    = bit_cnt_reg;
        byte_index_next = byte_index_reg;
        skip_next       = skip_reg;
        pos_i_next      = pos_i_reg;
        pos_j_next      = pos_j_reg;
        edge_next       = edge_reg;
        side_next       = side_reg;
        mono_next       = mono_reg;
        best_next       = best_reg;
        step_next       = step_reg;
        flip_next       = flip_reg;
        place_en        = 1'b0;
        line_clear      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (byte_fire)
                begin
                    if (byte_index_reg != 5'h1f)
                    begin
                        byte_index_next = byte_index_reg + 5'd1;
                    end
                    skip_next = skip_new;
                    if (decode_go)
                    begin
                        state_next   = ST_DECODE;
                        val_next     = size_val[5:0];
                        last_next    = byte_item.line_end;
                        bit_cnt_next = '0;
                    end
                    else if (byte_item.line_end)
                    begin
                        if (!skip_new)
                        begin
                            state_next = ST_START;
                        end
                        else
                        begin
                            line_clear = 1'b1;
                        end
                    end
                end
            end
            ST_DECODE:
            begin
                place_en = cur_bit && (32'(pos_j_reg) < 32'(vertex_count));
                if (place_en)
                begin
                    edge_next = edge_reg + 1'b1;
                end
                if (pos_j_reg != JW'(MAX_VERTICES))
                begin
                    if (JW'(pos_i_reg) + 1'b1 == pos_j_reg)
                    begin
                        pos_i_next = '0;
                        pos_j_next = pos_j_reg + 1'b1;
                    end
                    else
                    begin
                        pos_i_next = pos_i_reg + 1'b1;
                    end
                end
                if (bit_cnt_reg == LAST_BIT_SLOT)
                begin
                    state_next = last_reg ? ST_START : ST_IDLE;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                end
            end
            ST_START:
            begin
                mono_next  = edge_reg;
                best_next  = edge_reg;
                side_next  = '0;
                step_next  = KW'(1);
                flip_next  = VW'(1);
                state_next = (edge_reg == '0) ? ST_FINISH : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                mono_next = mono_new;
                side_next = side_reg ^ (MAX_VERTICES'(1) << flip_reg);
                if (mono_new < best_reg)
                begin
                    best_next = mono_new;
                end
                step_next = step_inc;
                flip_next = flip_after;
                if ((step_reg == step_last) || (mono_new == '0))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fin_ready)
                begin
                    state_next = ST_IDLE;
                    line_clear = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (line_clear)
        begin
            byte_index_next = '0;
            skip_next       = 1'b0;
            pos_i_next      = '0;
            pos_j_next      = JW'(1);
            edge_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_index_reg <= '0;
            skip_reg       <= 1'b0;
            pos_i_reg      <= '0;
            pos_j_reg      <= JW'(1);
            edge_reg       <= '0;
            bit_cnt_reg    <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_index_reg <= byte_index_next;
            skip_reg       <= skip_next;
            pos_i_reg      <= pos_i_next;
            pos_j_reg      <= pos_j_next;
            edge_reg       <= edge_next;
            bit_cnt_reg    <= bit_cnt_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        side_reg <= side_next;
        mono_reg <= mono_next;
        best_reg <= best_next;
        step_reg <= step_next;
        flip_reg <= flip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '{default: '0};
        end
        else if (line_clear)
        begin
            rows_reg <= '{default: '0};
        end
        else if (place_en)
        begin
            rows_reg[pos_i_reg][pos_j_reg[VW-1:0]] <= 1'b1;
            rows_reg[pos_j_reg[VW-1:0]][pos_i_reg] <= 1'b1;
        end
    end

    assign fin_valid = (state_reg == ST_FINISH);

    gr6_stats #(
        .MAX_VERTICES (MAX_VERTICES),
        .EW           (EW)
    ) u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_edge  (edge_reg),
        .fin_best  (best_reg),
        .fin_n     (vertex_count),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    `ASSERT_IMPL(a_best_within_edges, state_reg == ST_SEARCH, best_reg <= edge_reg, "search minimum above edge count")
    `ASSERT_IMPL(a_vertex0_pinned, state_reg == ST_SEARCH, side_reg[0] == 1'b0, "vertex 0 moved during search")
    `ASSERT_NEXT(a_skipped_line_end, byte_fire && byte_item.line_end && !decode_go && skip_new, (state_reg == ST_IDLE) && (byte_index_reg == 5'd0), "skipped line did not clear")

endmodule
